### src/hhpc_pkg.sv
// types, codes and reset constants shared by the heater controller files
package hhpc_pkg;

  localparam int TempW    = 8;
  localparam int ElapsedW = 16;
  localparam int TimeW    = 19;
  localparam int TimerW   = 20;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 19;

  // wash phase codes, code 3 means nothing and acts as another phase
  typedef enum logic [1:0] {
    PHASE_OTHER = 2'd0,
    PHASE_WASH  = 2'd1,
    PHASE_STEAM = 2'd2
  } phase_e;

  // wash sub-step codes, code 3 matches no heating step
  typedef enum logic [1:0] {
    SUB_OTHER     = 2'd0,
    SUB_STEAMTECH = 2'd1,
    SUB_HEATING   = 2'd2
  } substep_e;

  typedef enum logic [1:0] {
    DRIVE_OFF = 2'd0,
    DRIVE_ONE = 2'd1,
    DRIVE_TWO = 2'd2
  } drive_e;

  typedef enum logic [1:0] {
    STEP_ARM = 2'd0,
    STEP_TWO = 2'd1,
    STEP_ONE = 2'd2
  } step_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STEAMTECH_ON  = 3'd0,
    CFG_STEAMTECH_OFF = 3'd1,
    CFG_HEATING_ON    = 3'd2,
    CFG_HEATING_OFF   = 3'd3,
    CFG_STEAM_TARGET  = 3'd4,
    CFG_ONE_PLATE_MS  = 3'd5
  } cfg_idx_e;

  localparam logic [TempW-1:0] RstSteamtechOn  = 8'd60;
  localparam logic [TempW-1:0] RstSteamtechOff = 8'd55;
  localparam logic [TempW-1:0] RstHeatingOn    = 8'd40;
  localparam logic [TempW-1:0] RstHeatingOff   = 8'd35;
  localparam logic [TempW-1:0] RstSteamTarget  = 8'd90;
  localparam logic [TimeW-1:0] RstOnePlateMs   = 19'd300000;

  typedef struct packed {
    logic [TempW-1:0] steamtech_on;
    logic [TempW-1:0] steamtech_off;
    logic [TempW-1:0] heating_on;
    logic [TempW-1:0] heating_off;
    logic [TempW-1:0] steam_target;
    logic [TimeW-1:0] one_plate_ms;
  } cfg_t;

  typedef struct packed {
    logic [ElapsedW-1:0] elapsed_ms;
    logic [TempW-1:0]    temperature;
    logic [1:0]          wash_phase;
    logic [1:0]          wash_substep;
    logic                steam_tech_selected;
    logic                water_heating_selected;
  } item_t;

  typedef struct packed {
    logic              hyst_on;
    step_e             steam_step;
    logic [TimerW-1:0] timer;
    drive_e            drive_hold;
  } state_t;

  typedef struct packed {
    logic [1:0] plate_drive;
    logic       loop_wants_heat;
  } result_t;

endpackage

### src/hhpc_if.sv
// valid/ready channel interfaces for tick items and drive results
interface hhpc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] elapsed_ms;
  logic [7:0]  temperature;
  logic [1:0]  wash_phase;
  logic [1:0]  wash_substep;
  logic        steam_tech_selected;
  logic        water_heating_selected;

  modport source (
    output valid, elapsed_ms, temperature, wash_phase, wash_substep,
           steam_tech_selected, water_heating_selected,
    input  ready
  );
  modport sink (
    input  valid, elapsed_ms, temperature, wash_phase, wash_substep,
           steam_tech_selected, water_heating_selected,
    output ready
  );
endinterface

interface hhpc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] plate_drive;
  logic       loop_wants_heat;

  modport source (
    output valid, plate_drive, loop_wants_heat,
    input  ready
  );
  modport sink (
    input  valid, plate_drive, loop_wants_heat,
    output ready
  );
endinterface

### src/hhpc_step.sv
// next-state and result logic for one tick of the heater controller
module hhpc_step (
  input  hhpc_pkg::cfg_t    cfg_i,
  input  hhpc_pkg::state_t  state_i,
  input  hhpc_pkg::item_t   item_i,
  output hhpc_pkg::state_t  state_o,
  output hhpc_pkg::result_t result_o
);

  logic                            use_steamtech;
  logic                            use_heating;
  logic [hhpc_pkg::TempW-1:0]      on_lim;
  logic [hhpc_pkg::TempW-1:0]      off_lim;
  logic [hhpc_pkg::TimerW-1:0]     timer_sum;
  logic                            timer_done;

  // heating step selection and its limit pair
  assign use_steamtech = item_i.steam_tech_selected &&
                         (item_i.wash_substep == hhpc_pkg::SUB_STEAMTECH);
  assign use_heating   = item_i.water_heating_selected &&
                         (item_i.wash_substep == hhpc_pkg::SUB_HEATING);
  assign on_lim  = use_steamtech ? cfg_i.steamtech_on  : cfg_i.heating_on;
  assign off_lim = use_steamtech ? cfg_i.steamtech_off : cfg_i.heating_off;

  // one-plate interval timer, wraps at its own width
  assign timer_sum  = state_i.timer + hhpc_pkg::TimerW'(item_i.elapsed_ms);
  assign timer_done = timer_sum >= hhpc_pkg::TimerW'(cfg_i.one_plate_ms);

  // phase dispatch
  always_comb begin
    state_o = state_i;
    case (item_i.wash_phase)
      hhpc_pkg::PHASE_WASH: begin
        if (use_steamtech || use_heating) begin
          if (state_i.hyst_on) begin
            state_o.drive_hold = hhpc_pkg::DRIVE_TWO;
            if (item_i.temperature >= on_lim) state_o.hyst_on = 1'b0;
          end else begin
            state_o.drive_hold = hhpc_pkg::DRIVE_OFF;
            if (item_i.temperature <= off_lim) state_o.hyst_on = 1'b1;
          end
        end else begin
          state_o.drive_hold = hhpc_pkg::DRIVE_OFF;
          state_o.hyst_on    = 1'b1;
        end
      end
      hhpc_pkg::PHASE_STEAM: begin
        case (state_i.steam_step)
          hhpc_pkg::STEP_ARM: begin
            state_o.steam_step = hhpc_pkg::STEP_TWO;
            state_o.timer      = '0;
          end
          hhpc_pkg::STEP_TWO: begin
            state_o.drive_hold = hhpc_pkg::DRIVE_TWO;
            if (item_i.temperature >= cfg_i.steam_target) begin
              state_o.steam_step = hhpc_pkg::STEP_ONE;
              state_o.timer      = '0;
            end
          end
          hhpc_pkg::STEP_ONE: begin
            state_o.drive_hold = hhpc_pkg::DRIVE_ONE;
            if (timer_done) begin
              state_o.timer      = '0;
              state_o.steam_step = hhpc_pkg::STEP_TWO;
            end else begin
              state_o.timer = timer_sum;
            end
          end
          default: begin
            state_o = state_i;
          end
        endcase
      end
      default: begin
        state_o.drive_hold = hhpc_pkg::DRIVE_OFF;
      end
    endcase
  end

  // result is the state after the tick
  assign result_o.plate_drive     = state_o.drive_hold;
  assign result_o.loop_wants_heat = state_o.hyst_on;

endmodule

### src/heater_hysteresis_pattern_controller.sv
// Two-plate heater controller: hysteresis loop in the wash phase, two-plate /
// one-plate pattern in the steam phase. One tick transaction is accepted every
// clock cycle while the result register is free or being taken. Its result
// goes through the input register, then the combinational state update in
// hhpc_step that feeds the result register; that state update lets each tick
// follow the last one without a wait. Configuration registers are written
// through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must do so only while no
// tick is in flight, as the block does not enforce it. Unknown indexes are
// ignored.
module heater_hysteresis_pattern_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hhpc_in_if.sink                       in_i,
  hhpc_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [hhpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hhpc_pkg::CfgDataW-1:0] cfg_wdata_i
);

  hhpc_pkg::cfg_t    cfg_q;
  hhpc_pkg::item_t   item_q;
  hhpc_pkg::state_t  state_q;
  hhpc_pkg::state_t  state_d;
  hhpc_pkg::result_t res_q;
  hhpc_pkg::result_t res_d;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              out_free;
  logic              adv;
  logic              in_accept;

  // handshake: output register frees the input stage
  assign out_free  = !out_valid_q || out_o.ready;
  assign adv       = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || out_free;
  assign in_accept = in_i.valid && in_i.ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.steamtech_on  <= hhpc_pkg::RstSteamtechOn;
      cfg_q.steamtech_off <= hhpc_pkg::RstSteamtechOff;
      cfg_q.heating_on    <= hhpc_pkg::RstHeatingOn;
      cfg_q.heating_off   <= hhpc_pkg::RstHeatingOff;
      cfg_q.steam_target  <= hhpc_pkg::RstSteamTarget;
      cfg_q.one_plate_ms  <= hhpc_pkg::RstOnePlateMs;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hhpc_pkg::CFG_STEAMTECH_ON:  cfg_q.steamtech_on  <= cfg_wdata_i[hhpc_pkg::TempW-1:0];
        hhpc_pkg::CFG_STEAMTECH_OFF: cfg_q.steamtech_off <= cfg_wdata_i[hhpc_pkg::TempW-1:0];
        hhpc_pkg::CFG_HEATING_ON:    cfg_q.heating_on    <= cfg_wdata_i[hhpc_pkg::TempW-1:0];
        hhpc_pkg::CFG_HEATING_OFF:   cfg_q.heating_off   <= cfg_wdata_i[hhpc_pkg::TempW-1:0];
        hhpc_pkg::CFG_STEAM_TARGET:  cfg_q.steam_target  <= cfg_wdata_i[hhpc_pkg::TempW-1:0];
        hhpc_pkg::CFG_ONE_PLATE_MS:  cfg_q.one_plate_ms  <= cfg_wdata_i[hhpc_pkg::TimeW-1:0];
        default: begin
        end
      endcase
    end
  end

  // input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.elapsed_ms             <= in_i.elapsed_ms;
      item_q.temperature            <= in_i.temperature;
      item_q.wash_phase             <= in_i.wash_phase;
      item_q.wash_substep           <= in_i.wash_substep;
      item_q.steam_tech_selected    <= in_i.steam_tech_selected;
      item_q.water_heating_selected <= in_i.water_heating_selected;
    end
  end

  hhpc_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.hyst_on    <= 1'b1;
      state_q.steam_step <= hhpc_pkg::STEP_ARM;
      state_q.timer      <= '0;
      state_q.drive_hold <= hhpc_pkg::DRIVE_OFF;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.plate_drive     = res_q.plate_drive;
  assign out_o.loop_wants_heat = res_q.loop_wants_heat;

`ifndef ASSERT_OFF
  // state only moves when a tick advances into the result register
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(state_q))
    else $error("controller state changed without a tick");

  // an advancing tick always produces a result
  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_o.valid)
    else $error("tick advanced but no result shown");

  // phases other than wash and steam turn the plates off
  a_other_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (item_q.wash_phase != hhpc_pkg::PHASE_WASH) &&
    (item_q.wash_phase != hhpc_pkg::PHASE_STEAM)
    |=> out_o.plate_drive == hhpc_pkg::DRIVE_OFF)
    else $error("plates driven outside wash and steam phases");

  // wash phase with no heating step re-arms the loop
  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (item_q.wash_phase == hhpc_pkg::PHASE_WASH) &&
    (item_q.wash_substep == hhpc_pkg::SUB_OTHER)
    |=> out_o.loop_wants_heat && (out_o.plate_drive == hhpc_pkg::DRIVE_OFF))
    else $error("loop not re-armed in wash phase without heating step");
`endif

endmodule

### bench/tb_heater_hysteresis_pattern_controller.sv
// self-checking bench for the heater controller: directed ticks, then random ticks
`timescale 1ns / 100ps

module tb_heater_hysteresis_pattern_controller;

  // codes that exist on the wires but carry no meaning, then drain settle and pass length
  localparam logic [1:0]                   PhaseUnused  = 2'd3;
  localparam logic [1:0]                   SubUnused    = 2'd3;
  localparam logic [hhpc_pkg::CfgIdxW-1:0] CfgIdxSpareA = 3'd6;
  localparam logic [hhpc_pkg::CfgIdxW-1:0] CfgIdxSpareB = 3'd7;
  localparam int                           SettleCycles = 6;
  localparam int                           TicksPerPass = 50;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [hhpc_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [hhpc_pkg::CfgDataW-1:0] cfg_wdata_i;

  hhpc_in_if  in_ch ();
  hhpc_out_if out_ch ();

  heater_hysteresis_pattern_controller uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // mirror of the controller state and its registers
  hhpc_pkg::cfg_t              heater_cfg;
  logic                        loop_heat;
  hhpc_pkg::step_e             pattern_step;
  logic [hhpc_pkg::TimerW-1:0] plate_timer;
  hhpc_pkg::drive_e            held_drive;

  hhpc_pkg::result_t pending_drive[$];
  int                mismatch_count = 0;
  int                tx_idle_pct    = 0;
  int                rx_stall_pct   = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // bang-bang loop around one limit pair
  function automatic void heat_loop(logic [hhpc_pkg::TempW-1:0] temp,
                                    logic [hhpc_pkg::TempW-1:0] on_lim,
                                    logic [hhpc_pkg::TempW-1:0] off_lim);
    if (loop_heat) begin
      held_drive = hhpc_pkg::DRIVE_TWO;
      if (temp >= on_lim) loop_heat = 1'b0;
    end else begin
      held_drive = hhpc_pkg::DRIVE_OFF;
      if (temp <= off_lim) loop_heat = 1'b1;
    end
  endfunction

  // advance the mirrored state by one tick and return the drive it shows
  function automatic hhpc_pkg::result_t advance_heater(hhpc_pkg::item_t t);
    hhpc_pkg::result_t r;
    if (t.wash_phase == hhpc_pkg::PHASE_WASH) begin
      if (t.steam_tech_selected && t.wash_substep == hhpc_pkg::SUB_STEAMTECH) begin
        heat_loop(t.temperature, heater_cfg.steamtech_on, heater_cfg.steamtech_off);
      end else if (t.water_heating_selected && t.wash_substep == hhpc_pkg::SUB_HEATING) begin
        heat_loop(t.temperature, heater_cfg.heating_on, heater_cfg.heating_off);
      end else begin
        held_drive = hhpc_pkg::DRIVE_OFF;
        loop_heat  = 1'b1;
      end
    end else if (t.wash_phase == hhpc_pkg::PHASE_STEAM) begin
      case (pattern_step)
        hhpc_pkg::STEP_ARM: begin
          pattern_step = hhpc_pkg::STEP_TWO;
          plate_timer  = '0;
        end
        hhpc_pkg::STEP_TWO: begin
          held_drive = hhpc_pkg::DRIVE_TWO;
          if (t.temperature >= heater_cfg.steam_target) begin
            pattern_step = hhpc_pkg::STEP_ONE;
            plate_timer  = '0;
          end
        end
        hhpc_pkg::STEP_ONE: begin
          held_drive  = hhpc_pkg::DRIVE_ONE;
          plate_timer = plate_timer + hhpc_pkg::TimerW'(t.elapsed_ms);
          if (plate_timer >= hhpc_pkg::TimerW'(heater_cfg.one_plate_ms)) begin
            plate_timer  = '0;
            pattern_step = hhpc_pkg::STEP_TWO;
          end
        end
        default: ;
      endcase
    end else begin
      held_drive = hhpc_pkg::DRIVE_OFF;
    end
    r.plate_drive     = held_drive;
    r.loop_wants_heat = loop_heat;
    return r;
  endfunction

  function automatic hhpc_pkg::item_t make_tick(logic [hhpc_pkg::ElapsedW-1:0] elapsed,
                                                logic [hhpc_pkg::TempW-1:0] temp,
                                                logic [1:0] phase, logic [1:0] sub,
                                                logic st, logic wh);
    hhpc_pkg::item_t t;
    t.elapsed_ms             = elapsed;
    t.temperature            = temp;
    t.wash_phase             = phase;
    t.wash_substep           = sub;
    t.steam_tech_selected    = st;
    t.water_heating_selected = wh;
    return t;
  endfunction

  // random tick, temperature mostly close to one of the active limits
  function automatic hhpc_pkg::item_t rand_tick();
    hhpc_pkg::item_t t;
    int              pick;
    int              deg;
    pick = $urandom_range(0, 9);
    t.wash_phase = (pick < 4) ? hhpc_pkg::PHASE_WASH : (pick < 8) ? hhpc_pkg::PHASE_STEAM :
                   (pick == 8) ? hhpc_pkg::PHASE_OTHER : PhaseUnused;
    pick = $urandom_range(0, 9);
    t.wash_substep = (pick < 4) ? hhpc_pkg::SUB_STEAMTECH :
                     (pick < 8) ? hhpc_pkg::SUB_HEATING :
                     (pick == 8) ? hhpc_pkg::SUB_OTHER : SubUnused;
    t.steam_tech_selected    = ($urandom_range(0, 3) != 0);
    t.water_heating_selected = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 5))
      0: deg = $urandom_range(0, 255);
      1: deg = int'(heater_cfg.steamtech_on);
      2: deg = int'(heater_cfg.steamtech_off);
      3: deg = int'(heater_cfg.heating_on);
      4: deg = int'(heater_cfg.heating_off);
      default: deg = int'(heater_cfg.steam_target);
    endcase
    deg = deg + $urandom_range(0, 6) - 3;
    if (deg < 0) deg = 0;
    if (deg > 255) deg = 255;
    t.temperature = deg[hhpc_pkg::TempW-1:0];
    t.elapsed_ms  = ($urandom_range(0, 3) == 0) ?
                    hhpc_pkg::ElapsedW'($urandom_range(0, 15)) :
                    hhpc_pkg::ElapsedW'($urandom_range(0, 65535));
    return t;
  endfunction

  // one tick transaction, with an optional idle gap ahead of it
  task automatic send_tick(input hhpc_pkg::item_t t);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid                  <= 1'b1;
    in_ch.elapsed_ms             <= t.elapsed_ms;
    in_ch.temperature            <= t.temperature;
    in_ch.wash_phase             <= t.wash_phase;
    in_ch.wash_substep           <= t.wash_substep;
    in_ch.steam_tech_selected    <= t.steam_tech_selected;
    in_ch.water_heating_selected <= t.water_heating_selected;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pending_drive.push_back(advance_heater(t));
  endtask

  // stop sending and let every expected result come out
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_drive.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [hhpc_pkg::CfgIdxW-1:0] idx,
                           input logic [hhpc_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      hhpc_pkg::CFG_STEAMTECH_ON:  heater_cfg.steamtech_on  = data[hhpc_pkg::TempW-1:0];
      hhpc_pkg::CFG_STEAMTECH_OFF: heater_cfg.steamtech_off = data[hhpc_pkg::TempW-1:0];
      hhpc_pkg::CFG_HEATING_ON:    heater_cfg.heating_on    = data[hhpc_pkg::TempW-1:0];
      hhpc_pkg::CFG_HEATING_OFF:   heater_cfg.heating_off   = data[hhpc_pkg::TempW-1:0];
      hhpc_pkg::CFG_STEAM_TARGET:  heater_cfg.steam_target  = data[hhpc_pkg::TempW-1:0];
      hhpc_pkg::CFG_ONE_PLATE_MS:  heater_cfg.one_plate_ms  = data[hhpc_pkg::TimeW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // full register set, plus writes to the spare indexes that must not land
  task automatic write_all(input logic [hhpc_pkg::TempW-1:0] st_on,
                           input logic [hhpc_pkg::TempW-1:0] st_off,
                           input logic [hhpc_pkg::TempW-1:0] h_on,
                           input logic [hhpc_pkg::TempW-1:0] h_off,
                           input logic [hhpc_pkg::TempW-1:0] target,
                           input logic [hhpc_pkg::TimeW-1:0] ms);
    write_reg(hhpc_pkg::CFG_STEAMTECH_ON, hhpc_pkg::CfgDataW'(st_on));
    write_reg(hhpc_pkg::CFG_STEAMTECH_OFF, hhpc_pkg::CfgDataW'(st_off));
    write_reg(hhpc_pkg::CFG_HEATING_ON, hhpc_pkg::CfgDataW'(h_on));
    write_reg(hhpc_pkg::CFG_HEATING_OFF, hhpc_pkg::CfgDataW'(h_off));
    write_reg(hhpc_pkg::CFG_STEAM_TARGET, hhpc_pkg::CfgDataW'(target));
    write_reg(hhpc_pkg::CFG_ONE_PLATE_MS, hhpc_pkg::CfgDataW'(ms));
    write_reg(CfgIdxSpareA, hhpc_pkg::CfgDataW'($urandom_range(0, 524287)));
    write_reg(CfgIdxSpareB, hhpc_pkg::CfgDataW'($urandom_range(0, 524287)));
  endtask

  // hysteresis loop with both limit pairs, fallbacks and unused codes
  task automatic test_wash_hysteresis();
    send_tick(make_tick(16'd0, 8'd0, hhpc_pkg::PHASE_WASH, hhpc_pkg::SUB_STEAMTECH, 1'b1, 1'b0));
    send_tick(make_tick(16'd100, 8'd60, hhpc_pkg::PHASE_WASH, hhpc_pkg::SUB_STEAMTECH,
                        1'b1, 1'b0));
    send_tick(make_tick(16'd100, 8'd56, hhpc_pkg::PHASE_WASH, hhpc_pkg::SUB_STEAMTECH,
                        1'b1, 1'b1));
    send_tick(make_tick(16'd100, 8'd55, hhpc_pkg::PHASE_WASH, hhpc_pkg::SUB_STEAMTECH,
                        1'b1, 1'b0));
    send_tick(make_tick(16'd100, 8'd255, hhpc_pkg::PHASE_WASH, hhpc_pkg::SUB_HEATING,
                        1'b0, 1'b1));
    send_tick(make_tick(16'd100, 8'd36, hhpc_pkg::PHASE_WASH, hhpc_pkg::SUB_HEATING,
                        1'b0, 1'b1));
    send_tick(make_tick(16'd100, 8'd20, hhpc_pkg::PHASE_WASH, hhpc_pkg::SUB_HEATING,
                        1'b1, 1'b0));
    send_tick(make_tick(16'd100, 8'd255, hhpc_pkg::PHASE_WASH, hhpc_pkg::SUB_STEAMTECH,
                        1'b0, 1'b1));
    send_tick(make_tick(16'd100, 8'd255, hhpc_pkg::PHASE_WASH, SubUnused, 1'b1, 1'b1));
    send_tick(make_tick(16'd100, 8'd70, hhpc_pkg::PHASE_WASH, hhpc_pkg::SUB_OTHER,
                        1'b1, 1'b1));
    send_tick(make_tick(16'hFFFF, 8'd255, PhaseUnused, hhpc_pkg::SUB_STEAMTECH, 1'b1, 1'b1));
    send_tick(make_tick(16'd0, 8'd0, hhpc_pkg::PHASE_OTHER, hhpc_pkg::SUB_HEATING, 1'b1, 1'b1));
  endtask

  // arming tick, target crossing, persistence, and a zero-length interval
  task automatic test_steam_pattern();
    send_tick(make_tick(16'hFFFF, 8'd255, hhpc_pkg::PHASE_STEAM, hhpc_pkg::SUB_OTHER,
                        1'b0, 1'b0));
    send_tick(make_tick(16'd10, 8'd89, hhpc_pkg::PHASE_STEAM, hhpc_pkg::SUB_OTHER, 1'b0, 1'b0));
    send_tick(make_tick(16'd10, 8'd90, hhpc_pkg::PHASE_STEAM, hhpc_pkg::SUB_OTHER, 1'b0, 1'b0));
    send_tick(make_tick(16'd10, 8'd0, hhpc_pkg::PHASE_OTHER, hhpc_pkg::SUB_OTHER, 1'b0, 1'b0));
    send_tick(make_tick(16'hFFFF, 8'd0, hhpc_pkg::PHASE_STEAM, hhpc_pkg::SUB_OTHER,
                        1'b0, 1'b0));
    send_tick(make_tick(16'd10, 8'd0, hhpc_pkg::PHASE_WASH, hhpc_pkg::SUB_STEAMTECH,
                        1'b1, 1'b0));
    send_tick(make_tick(16'hFFFF, 8'd0, hhpc_pkg::PHASE_STEAM, hhpc_pkg::SUB_OTHER,
                        1'b0, 1'b0));
    drain();
    write_reg(hhpc_pkg::CFG_ONE_PLATE_MS, '0);
    send_tick(make_tick(16'd0, 8'd0, hhpc_pkg::PHASE_STEAM, hhpc_pkg::SUB_OTHER, 1'b1, 1'b1));
    send_tick(make_tick(16'd0, 8'd255, hhpc_pkg::PHASE_STEAM, hhpc_pkg::SUB_OTHER, 1'b1, 1'b1));
    send_tick(make_tick(16'd0, 8'd0, hhpc_pkg::PHASE_STEAM, hhpc_pkg::SUB_OTHER, 1'b1, 1'b1));
    drain();
  endtask

  // random ticks over every idle pattern and several register settings
  task automatic test_random_ticks();
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
        default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
      endcase
      for (int setting = 0; setting < 4; setting++) begin
        case (setting)
          0: write_all(hhpc_pkg::RstSteamtechOn, hhpc_pkg::RstSteamtechOff,
                       hhpc_pkg::RstHeatingOn, hhpc_pkg::RstHeatingOff,
                       hhpc_pkg::RstSteamTarget, hhpc_pkg::RstOnePlateMs);
          1: write_all('0, '0, '0, '0, '0, '0);
          2: write_all('1, '1, '1, '1, '1, '1);
          default: write_all(hhpc_pkg::TempW'($urandom_range(0, 255)),
                             hhpc_pkg::TempW'($urandom_range(0, 255)),
                             hhpc_pkg::TempW'($urandom_range(0, 255)),
                             hhpc_pkg::TempW'($urandom_range(0, 255)),
                             hhpc_pkg::TempW'($urandom_range(0, 255)),
                             hhpc_pkg::TimeW'($urandom_range(1, 200000)));
        endcase
        for (int n = 0; n < TicksPerPass; n++) send_tick(rand_tick());
        drain();
      end
    end
  endtask

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    hhpc_pkg::result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_drive.size() == 0) begin
        $error("unexpected result: plate_drive %0d loop_wants_heat %0d",
               out_ch.plate_drive, out_ch.loop_wants_heat);
        mismatch_count++;
      end else begin
        want = pending_drive.pop_front();
        if (out_ch.plate_drive !== want.plate_drive) begin
          $error("plate_drive mismatch: expected %0d actual %0d",
                 want.plate_drive, out_ch.plate_drive);
          mismatch_count++;
        end
        if (out_ch.loop_wants_heat !== want.loop_wants_heat) begin
          $error("loop_wants_heat mismatch: expected %0d actual %0d",
                 want.loop_wants_heat, out_ch.loop_wants_heat);
          mismatch_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    rst_ni                       = 1'b0;
    cfg_we_i                     = 1'b0;
    cfg_idx_i                    = '0;
    cfg_wdata_i                  = '0;
    in_ch.valid                  = 1'b0;
    in_ch.elapsed_ms             = '0;
    in_ch.temperature            = '0;
    in_ch.wash_phase             = '0;
    in_ch.wash_substep           = '0;
    in_ch.steam_tech_selected    = 1'b0;
    in_ch.water_heating_selected = 1'b0;
    heater_cfg.steamtech_on      = hhpc_pkg::RstSteamtechOn;
    heater_cfg.steamtech_off     = hhpc_pkg::RstSteamtechOff;
    heater_cfg.heating_on        = hhpc_pkg::RstHeatingOn;
    heater_cfg.heating_off       = hhpc_pkg::RstHeatingOff;
    heater_cfg.steam_target      = hhpc_pkg::RstSteamTarget;
    heater_cfg.one_plate_ms      = hhpc_pkg::RstOnePlateMs;
    loop_heat                    = 1'b1;
    pattern_step                 = hhpc_pkg::STEP_ARM;
    plate_timer                  = '0;
    held_drive                   = hhpc_pkg::DRIVE_OFF;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_wash_hysteresis();
    test_steam_pattern();
    test_random_ticks();
    drain();

    if (mismatch_count == 0) begin
      $display("heater_hysteresis_pattern_controller verification clean");
    end else begin
      $display("heater_hysteresis_pattern_controller verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("heater_hysteresis_pattern_controller verification failed");
    $finish;
  end

endmodule

### filelist.f
src/hhpc_pkg.sv
src/hhpc_if.sv
src/hhpc_step.sv
src/heater_hysteresis_pattern_controller.sv
bench/tb_heater_hysteresis_pattern_controller.sv
